// ----- hdl/gcrl_pkg.sv -----
// Shared types, constants and the arctangent table for the route length block.
package gcrl_pkg;

    localparam int CW = 36;                        // CORDIC and product operand width
    typedef logic signed [CW-1:0] cval_t;

    typedef struct packed {
        logic load;
        logic step;
        logic vec;                                 // 1: vectoring (acos), 0: rotation
    } cordic_ctrl_t;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_DMUL, S_DINIT, S_DIV, S_CLOAD, S_CORD, S_CSAVE,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_SQ, S_SQI, S_SQRT, S_ALOAD, S_ACOS,
        S_MMUL, S_MM2, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        ANG_LAT_PREV = 2'd0,
        ANG_LAT_CUR  = 2'd1,
        ANG_DELTA    = 2'd2
    } ang_sel_t;

    localparam cval_t INV_GAIN = 36'sd652032874;
    localparam cval_t HALF_PI  = 36'sd1686629713;
    localparam cval_t Q30_ONE  = 36'sd1073741824;
    localparam cval_t EARTH_R  = 36'sd6371000;
    // udeg -> Q2.31 radians scale (2*pi*1e9 * 2^31 / 3.6e17) with 70 fraction bits
    localparam logic [159:0] RAD_SCALED =
        (160'd6283185307 << 101) / 160'd360000000000000000;
    localparam logic [5:0]  RAD_INT = RAD_SCALED[75:70];
    localparam logic [34:0] RAD_HI  = RAD_SCALED[69:35];
    localparam logic [34:0] RAD_LO  = RAD_SCALED[34:0];
    localparam logic signed [27:0] LAT_MAX = 28'sd90000000;
    localparam logic [29:0] DEG360 = 30'd360000000;
    localparam logic [29:0] DEG180 = 30'd180000000;
    localparam logic [29:0] DEG90  = 30'd90000000;

    function automatic logic [31:0] atan_q30(input logic [5:0] i);
        logic [31:0] r;
        unique case (i)
            6'd0:  r = 32'h3243F6A8;
            6'd1:  r = 32'h1DAC6705;
            6'd2:  r = 32'h0FADBAFC;
            6'd3:  r = 32'h07F56EA6;
            6'd4:  r = 32'h03FEAB76;
            6'd5:  r = 32'h01FFD55B;
            6'd6:  r = 32'h00FFFAAA;
            6'd7:  r = 32'h007FFF55;
            6'd8:  r = 32'h003FFFEA;
            6'd9:  r = 32'h001FFFFD;
            6'd10: r = 32'h000FFFFF;
            6'd11: r = 32'h0007FFFF;
            6'd12: r = 32'h0003FFFF;
            6'd13: r = 32'h0001FFFF;
            6'd14: r = 32'h0000FFFF;
            6'd15: r = 32'h00007FFF;
            6'd16: r = 32'h00003FFF;
            6'd17: r = 32'h00001FFF;
            6'd18: r = 32'h00000FFF;
            6'd19: r = 32'h000007FF;
            6'd20: r = 32'h000003FF;
            6'd21: r = 32'h000001FF;
            6'd22: r = 32'h000000FF;
            6'd23: r = 32'h0000007F;
            6'd24: r = 32'h0000003F;
            6'd25: r = 32'h0000001F;
            6'd26: r = 32'h0000000F;
            6'd27: r = 32'h00000008;
            6'd28: r = 32'h00000004;
            6'd29: r = 32'h00000002;
            6'd30: r = 32'h00000001;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/great_circle_route_length.sv -----
// Top level: route point stream in, segment / route length / point count out.
//
// Input beats (s_tdata, s_tuser) carry one route point: latitude and longitude
// in micro-degrees, tuser high starts a new route. Each beat yields exactly one
// output beat on m_*: the great-circle segment to the previous point in mm
// (zero for a route's first point), the running route length and point count,
// both saturating.
// One point is worked at a time; s_tready is high only while idle. A route's
// first point goes straight to the output stage. Any other point runs through
// a sequencer around one shared CORDIC stage and one multiplier: three
// conversions (N = min(CORDIC_STEPS,40) CORDIC steps each) for the two
// latitudes and the longitude difference (angle scaling by a split reciprocal
// product), then the products, square root and acos. The CORDIC iterations
// and the 31-step square root make up most of the work.
// The result sits in an output register; the next point is taken while it
// waits, and a stalled receiver (m_tready low) only holds the block once the
// following result is ready. Reset (aresetn low, synchronous) empties the
// output and forgets the previous point, so the next point starts a route.
module great_circle_route_length #(
    parameter int CORDIC_STEPS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [27:0] latitude_udeg, [56:28] longitude_udeg
    input  logic         s_tuser,   // [0] start_of_route
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // [34:0] segment_length_mm, [82:35] route_length_mm,
                                    // [98:83] point_count
);
    import gcrl_pkg::*;

    localparam int STEPS = (CORDIC_STEPS < 40) ? CORDIC_STEPS : 40;
    localparam logic [5:0] LAST = 6'(STEPS - 1);
    localparam logic [5:0] BIT_LAST = 6'd30;

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] ang_reg, ang_next;

    logic               have_prev_reg, have_prev_next;
    logic signed [27:0] prev_lat_reg, prev_lat_next, cur_lat_reg, cur_lat_next;
    logic signed [28:0] prev_lon_reg, prev_lon_next, cur_lon_reg, cur_lon_next;
    logic               clear_reg, clear_next;
    logic [29:0]        dabs_reg, dabs_next;
    logic [26:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [26:0]        part_reg, part_next;
    logic [31:0]        res_reg, res_next;
    cval_t              c1_reg, c1_next, s1_reg, s1_next, c2_reg, c2_next;
    cval_t              s2_reg, s2_next, cd_reg, cd_next;
    cval_t              t1_reg, t1_next, t2_reg, t2_next, cc_reg, cc_next;
    logic [60:0]        sv_reg, sv_next, sr_reg, sr_next;
    logic [34:0]        seg_reg, seg_next;
    logic [47:0]        len_reg, len_next;
    logic [15:0]        count_reg, count_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [103:0]       m_tdata_reg, m_tdata_next;
    logic signed [71:0] prod_reg;

    cval_t mul_a, mul_b;
    cordic_ctrl_t cctl;
    cval_t cx_init, cy_init, cz_init, cx, cy, cz;

    logic signed [28:0] in_lon;
    logic signed [29:0] dlon;
    logic signed [27:0] lat_sel, lat_clamped;
    logic [27:0]        lat_abs;
    logic [29:0]        fold0, fold1;
    logic               out_free;
    logic [62:0]        frac_sum;
    logic [31:0]        int_part;
    logic [32:0]        q_inc;
    cval_t              q_val, rm_prod, zpos;
    logic signed [36:0] csum;
    logic [60:0]        sq_bit;
    logic [61:0]        sq_try;
    logic [54:0]        hi;
    logic [34:0]        mm_int;
    logic [39:0]        mm_frac;
    logic [48:0]        len_sum;
    logic [47:0]        len_new;
    logic [15:0]        count_base, count_new;

    function automatic cval_t rmul(input logic signed [71:0] p);
        logic signed [71:0] t;
        t = p + 72'sd536870912;
        return cval_t'(t >>> 30);
    endfunction

    gcrl_cordic u_cordic (
        .aclk   (aclk),
        .ctrl   (cctl),
        .idx    (cnt_reg),
        .x_init (cx_init),
        .y_init (cy_init),
        .z_init (cz_init),
        .x_out  (cx),
        .y_out  (cy),
        .z_out  (cz)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // longitude difference magnitude, taken when the point arrives
    assign in_lon = s_tdata[56:28];
    assign dlon   = {prev_lon_reg[28], prev_lon_reg} - {in_lon[28], in_lon};

    // latitude clamp and magnitude
    assign lat_sel = (ang_reg == ANG_LAT_PREV) ? prev_lat_reg : cur_lat_reg;
    always_comb begin
        if (lat_sel > LAT_MAX) begin
            lat_clamped = LAT_MAX;
        end else if (lat_sel < -LAT_MAX) begin
            lat_clamped = -LAT_MAX;
        end else begin
            lat_clamped = lat_sel;
        end
    end
    assign lat_abs = lat_clamped[27] ? 28'(-lat_clamped) : 28'(lat_clamped);

    // fold longitude difference into 0..180 degrees
    assign fold0 = (dabs_reg >= DEG360) ? dabs_reg - DEG360 : dabs_reg;
    assign fold1 = (fold0 > DEG180) ? DEG360 - fold0 : fold0;

    // angle in Q2.31: integer part of the scale by constant multiply, fraction
    // by two partial products; exact floor for magnitudes up to 90 degrees
    assign frac_sum  = {1'b0, prod_reg[61:0]} + {36'b0, part_reg};
    assign int_part  = 32'(mag_reg) * 32'(RAD_INT);
    assign q_inc     = {1'b0, res_reg} + 33'd1;
    assign q_val     = cval_t'(q_inc[32:1]);
    assign rm_prod   = rmul(prod_reg);
    assign csum      = {t1_reg[CW-1], t1_reg} + {rm_prod[CW-1], rm_prod};
    assign zpos      = (cz < 0) ? cval_t'(0) : cz;

    // isqrt trial bit walks down two places a step
    assign sq_bit = 61'd1 << (6'd60 - {cnt_reg[4:0], 1'b0});
    assign sq_try = {1'b0, sr_reg} + {1'b0, sq_bit};

    // mm = (hi >> 30) * 1000 + round((hi mod 2^30) * 1000 / 2^30)
    assign hi      = prod_reg[54:0];
    assign mm_int  = 35'(hi[54:30]) * 35'd1000;
    assign mm_frac = (40'(hi[29:0]) * 40'd1000 + 40'd536870912) >> 30;

    assign len_sum    = {1'b0, len_reg} + {14'b0, seg_reg};
    assign len_new    = clear_reg ? 48'd0 : (len_sum[48] ? '1 : len_sum[47:0]);
    assign count_base = clear_reg ? 16'd0 : count_reg;
    assign count_new  = (count_base == 16'hFFFF) ? count_base : count_base + 16'd1;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ang_next       = ang_reg;
        have_prev_next = have_prev_reg;
        prev_lat_next  = prev_lat_reg;
        prev_lon_next  = prev_lon_reg;
        cur_lat_next   = cur_lat_reg;
        cur_lon_next   = cur_lon_reg;
        clear_next     = clear_reg;
        dabs_next      = dabs_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        part_next      = part_reg;
        res_next       = res_reg;
        c1_next        = c1_reg;
        s1_next        = s1_reg;
        c2_next        = c2_reg;
        s2_next        = s2_reg;
        cd_next        = cd_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        cc_next        = cc_reg;
        sv_next        = sv_reg;
        sr_next        = sr_reg;
        seg_next       = seg_reg;
        len_next       = len_reg;
        count_next     = count_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        mul_a          = c1_reg;
        mul_b          = c2_reg;
        cctl           = '0;
        cx_init        = INV_GAIN;
        cy_init        = '0;
        cz_init        = q_val;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cur_lat_next = s_tdata[27:0];
                    cur_lon_next = in_lon;
                    dabs_next    = dlon[29] ? 30'(-dlon) : 30'(dlon);
                    clear_next   = s_tuser || !have_prev_reg;
                    seg_next     = '0;
                    ang_next     = ANG_LAT_PREV;
                    state_next   = (s_tuser || !have_prev_reg) ? S_DONE : S_PREP;
                end
            end
            S_PREP: begin
                if (ang_reg == ANG_DELTA) begin
                    neg_next = fold1 > DEG90;
                    mag_next = (fold1 > DEG90) ? 27'(DEG180 - fold1) : 27'(fold1);
                end else begin
                    neg_next = lat_clamped[27];
                    mag_next = lat_abs[26:0];
                end
                state_next = S_DMUL;
            end
            S_DMUL: begin
                mul_a      = cval_t'({9'b0, mag_reg});
                mul_b      = cval_t'({1'b0, RAD_LO});
                state_next = S_DINIT;
            end
            S_DINIT: begin
                // low partial product folds into the high one
                part_next  = prod_reg[61:35];
                mul_a      = cval_t'({9'b0, mag_reg});
                mul_b      = cval_t'({1'b0, RAD_HI});
                state_next = S_DIV;
            end
            S_DIV: begin
                res_next   = int_part + 32'(frac_sum[62:35]);
                state_next = S_CLOAD;
            end
            S_CLOAD: begin
                cctl.load = 1'b1;
                cz_init   = (neg_reg && ang_reg != ANG_DELTA) ? -q_val : q_val;
                cnt_next   = '0;
                state_next = S_CORD;
            end
            S_CORD: begin
                cctl.step = 1'b1;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == LAST) begin
                    state_next = S_CSAVE;
                end
            end
            S_CSAVE: begin
                unique case (ang_reg)
                    ANG_LAT_PREV: begin
                        c1_next = cx;
                        s1_next = cy;
                    end
                    ANG_LAT_CUR: begin
                        c2_next = cx;
                        s2_next = cy;
                    end
                    default: begin
                        cd_next = neg_reg ? -cx : cx;
                    end
                endcase
                if (ang_reg == ANG_DELTA) begin
                    state_next = S_M1;
                end else begin
                    ang_next   = ang_reg + 2'd1;
                    state_next = S_PREP;
                end
            end
            S_M1: begin
                mul_a      = s1_reg;
                mul_b      = s2_reg;
                state_next = S_M2;
            end
            S_M2: begin
                t1_next    = rm_prod;
                mul_a      = c1_reg;
                mul_b      = c2_reg;
                state_next = S_M3;
            end
            S_M3: begin
                t2_next    = rm_prod;
                state_next = S_M4;
            end
            S_M4: begin
                mul_a      = t2_reg;
                mul_b      = cd_reg;
                state_next = S_M5;
            end
            S_M5: begin
                if (csum > 37'(Q30_ONE)) begin
                    cc_next = Q30_ONE;
                end else if (csum < -37'(Q30_ONE)) begin
                    cc_next = -Q30_ONE;
                end else begin
                    cc_next = cval_t'(csum);
                end
                state_next = S_SQ;
            end
            S_SQ: begin
                mul_a      = cc_reg;
                mul_b      = cc_reg;
                state_next = S_SQI;
            end
            S_SQI: begin
                sv_next    = 61'h1000_0000_0000_0000 - prod_reg[60:0];
                sr_next    = '0;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                if ({1'b0, sv_reg} >= sq_try) begin
                    sv_next = sv_reg - sq_try[60:0];
                    sr_next = (sr_reg >> 1) + sq_bit;
                end else begin
                    sr_next = sr_reg >> 1;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == BIT_LAST) begin
                    state_next = S_ALOAD;
                end
            end
            S_ALOAD: begin
                cctl.load = 1'b1;
                cctl.vec  = 1'b1;
                if (cc_reg < 0) begin
                    cx_init = cval_t'(sr_reg[31:0]);
                    cy_init = -cc_reg;
                    cz_init = HALF_PI;
                end else begin
                    cx_init = cc_reg;
                    cy_init = cval_t'(sr_reg[31:0]);
                    cz_init = '0;
                end
                cnt_next   = '0;
                state_next = S_ACOS;
            end
            S_ACOS: begin
                cctl.step = 1'b1;
                cctl.vec  = 1'b1;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == LAST) begin
                    state_next = S_MMUL;
                end
            end
            S_MMUL: begin
                mul_a      = zpos;
                mul_b      = EARTH_R;
                state_next = S_MM2;
            end
            S_MM2: begin
                seg_next   = mm_int + mm_frac[34:0];
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    m_tdata_next   = {5'b0, count_new, len_new, seg_reg};
                    len_next       = len_new;
                    count_next     = count_new;
                    prev_lat_next  = cur_lat_reg;
                    prev_lon_next  = cur_lon_reg;
                    have_prev_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ang_reg       <= '0;
            have_prev_reg <= 1'b0;
            prev_lat_reg  <= '0;
            prev_lon_reg  <= '0;
            len_reg       <= '0;
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ang_reg       <= ang_next;
            have_prev_reg <= have_prev_next;
            prev_lat_reg  <= prev_lat_next;
            prev_lon_reg  <= prev_lon_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_lat_reg <= cur_lat_next;
        cur_lon_reg <= cur_lon_next;
        clear_reg   <= clear_next;
        dabs_reg    <= dabs_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        part_reg    <= part_next;
        res_reg     <= res_next;
        c1_reg      <= c1_next;
        s1_reg      <= s1_next;
        c2_reg      <= c2_next;
        s2_reg      <= s2_next;
        cd_reg      <= cd_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        cc_reg      <= cc_next;
        sv_reg      <= sv_next;
        sr_reg      <= sr_next;
        seg_reg     <= seg_next;
        m_tdata_reg <= m_tdata_next;
        prod_reg    <= 72'(mul_a) * 72'(mul_b);
    end

endmodule

// ----- hdl/gcrl_cordic.sv -----
// Shared CORDIC stage: x/y/z registers with one micro-rotation per cycle while step is set.
module gcrl_cordic (
    input  logic                    aclk,
    input  gcrl_pkg::cordic_ctrl_t  ctrl,
    input  logic [5:0]              idx,
    input  gcrl_pkg::cval_t         x_init,
    input  gcrl_pkg::cval_t         y_init,
    input  gcrl_pkg::cval_t         z_init,
    output gcrl_pkg::cval_t         x_out,
    output gcrl_pkg::cval_t         y_out,
    output gcrl_pkg::cval_t         z_out
);
    import gcrl_pkg::*;

    cval_t x_reg, y_reg, z_reg;
    cval_t x_next, y_next, z_next;
    cval_t dx, dy, at;
    logic  up;

    assign dx = y_reg >>> idx;
    assign dy = x_reg >>> idx;
    assign at = cval_t'({4'b0, atan_q30(idx)});
    // rotation follows the sign of z, vectoring drives y towards zero
    assign up = ctrl.vec ? !(y_reg > 0) : (z_reg >= 0);

    always_comb begin
        if (up) begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - at;
        end else begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            x_reg <= x_init;
            y_reg <= y_init;
            z_reg <= z_init;
        end else if (ctrl.step) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ----- tb/great_circle_route_length_check.sv -----
// Checker for the route length block: predicts each result beat and compares it.
module great_circle_route_length_check (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    output int           fail_count,
    output int           pending,
    output int           results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 32;
    localparam longint ONE = 64'sd1073741824;
    localparam logic [47:0] LEN_TOP = '1;

    typedef struct packed {
        logic [34:0] seg;
        logic [47:0] len;
        logic [15:0] cnt;
    } leg_t;

    leg_t   legs_due[$];
    longint last_lat, last_lon;
    bit     have_last;
    logic [47:0] route_len;
    logic [15:0] route_pts;

    function automatic longint atan_entry(input int i);
        longint t[31] = '{'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76,
            'h01FFD55B, 'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF,
            'h0007FFFF, 'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF,
            'h00001FFF, 'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF,
            'h0000007F, 'h0000003F, 'h0000001F, 'h0000000F, 'h8, 'h4, 'h2, 'h1};
        return i < 31 ? t[i] : 0;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + ONE / 2) >>> 30;
    endfunction

    // micro-degrees magnitude to Q2.30 radians, exact long division
    function automatic longint to_rad(input longint mag);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        num = 128'(mag) * 128'd6283185307;
        den = 128'd360000000000000000;
        q = (num << 31) / den;
        return longint'((q + 1) >> 1);
    endfunction

    function automatic void rotate(input longint ang, output longint cv, output longint sv);
        longint x, y, z, dx, dy;
        x = 652032874; y = 0; z = ang;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_entry(i);
            end else begin
                x += dx; y -= dy; z += atan_entry(i);
            end
        end
        cv = x; sv = y;
    endfunction

    function automatic longint root(input longint v);
        longint r, b;
        r = 0; b = longint'(1) << 60;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint arc_cos(input longint c);
        longint s, x, y, z, dx, dy;
        s = root(ONE * ONE - c * c);
        if (c < 0) begin
            x = s; y = -c; z = 1686629713;
        end else begin
            x = c; y = s; z = 0;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_entry(i);
            end else begin
                x -= dx; y += dy; z -= atan_entry(i);
            end
        end
        return z < 0 ? 0 : z;
    endfunction

    function automatic void lat_trig(input longint lat, output longint cv, output longint sv);
        longint q;
        if (lat > 90000000) lat = 90000000;
        if (lat < -90000000) lat = -90000000;
        q = to_rad(lat < 0 ? -lat : lat);
        rotate(lat < 0 ? -q : q, cv, sv);
    endfunction

    function automatic logic [34:0] arc_mm(input longint la1, input longint lo1,
                                           input longint la2, input longint lo2);
        longint c1, s1, c2, s2, cd, sd, c, z, m, hi;
        bit neg;
        lat_trig(la1, c1, s1);
        lat_trig(la2, c2, s2);
        m = lo1 - lo2;
        if (m < 0) m = -m;
        m = m % 360000000;
        neg = 0;
        if (m > 180000000) m = 360000000 - m;
        if (m > 90000000) begin
            m = 180000000 - m; neg = 1;
        end
        rotate(to_rad(m), cd, sd);
        if (neg) cd = -cd;
        c = qmul(s1, s2) + qmul(qmul(c1, c2), cd);
        if (c > ONE) c = ONE;
        if (c < -ONE) c = -ONE;
        z = arc_cos(c);
        hi = z * 6371000;
        return 35'((hi >> 30) * 1000 + (((hi & (ONE - 1)) * 1000 + ONE / 2) >> 30));
    endfunction

    always @(posedge aclk) begin
        leg_t   want, got;
        longint lat, lon;
        logic [48:0] sum;
        if (!aresetn) begin
            legs_due.delete();
            have_last <= 0;
            route_len <= 0;
            route_pts <= 0;
            fail_count <= 0;
            results_seen <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{seg: m_tdata[34:0], len: m_tdata[82:35], cnt: m_tdata[98:83]};
                results_seen <= results_seen + 1;
                if (legs_due.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected result beat %h", m_tdata);
                end else begin
                    want = legs_due.pop_front();
                    if (got !== want) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: seg %0d/%0d len %0d/%0d cnt %0d/%0d (exp/got)",
                                     want.seg, got.seg, want.len, got.len,
                                     want.cnt, got.cnt);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                lat = longint'($signed(s_tdata[27:0]));
                lon = longint'($signed(s_tdata[56:28]));
                want = '0;
                if (s_tuser || !have_last) begin
                    want.len = '0;
                    want.cnt = 16'd1;
                end else begin
                    want.seg = arc_mm(last_lat, last_lon, lat, lon);
                    sum = {1'b0, route_len} + 49'(want.seg);
                    want.len = sum[48] ? LEN_TOP : sum[47:0];
                    want.cnt = route_pts == 16'hFFFF ? route_pts : route_pts + 16'd1;
                end
                route_len <= want.len;
                route_pts <= want.cnt;
                last_lat <= lat;
                last_lon <= lon;
                have_last <= 1;
                legs_due.insert(legs_due.size(), want);
            end
        end
    end

    assign pending = legs_due.size();
endmodule

// ----- tb/great_circle_route_length_test.sv -----
// Testbench top: drives route points, stalls the receiver, gives the verdict.
module great_circle_route_length_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 3000000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [103:0] m_tdata;
    int           fail_count, pending, results_seen;
    int           send_idle = 0, recv_idle = 0;  // percent of cycles idled
    int           hold_cycles = 0;               // long receiver hold-off
    longint       cycles = 0;
    int           beats_sent = 0;

    always #1 aclk = ~aclk;

    great_circle_route_length uut (.*);

    great_circle_route_length_check checker_i (.*);

    // runaway guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off counted down here
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // drive one point; valid held until the beat is taken, dropped only on idle cycles
    task automatic send_point(input longint lat, input longint lon, input bit start);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {7'b0, 29'(lon), 28'(lat)};
        s_tuser <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        @(negedge aclk);
    endtask

    // mostly legal coordinates, occasionally any bit pattern (clamp, wrap)
    task automatic random_point(input bit start);
        longint lat, lon;
        int     k;
        k = $urandom_range(9);
        if (k == 0) begin
            lat = longint'($signed(28'($urandom)));
            lon = longint'($signed(29'($urandom)));
        end else if (k < 3) begin
            // short hop near the last point: tiny segments
            lat = longint'($signed(s_tdata[27:0])) + $signed($urandom_range(2000)) - 1000;
            lon = longint'($signed(s_tdata[56:28])) + $signed($urandom_range(2000)) - 1000;
            if (lat > 90000000 || lat < -90000000) lat = 0;
        end else begin
            lat = longint'($urandom_range(180000000)) - 90000000;
            lon = longint'($urandom_range(360000000)) - 180000000;
        end
        send_point(lat, lon, start);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: first point without a start flag still begins a route
        send_point(0, 0, 0);
        send_point(0, 0, 0);                       // zero segment
        send_point(90000000, 0, 0);                // pole
        send_point(-90000000, 0, 0);               // pole to pole
        send_point(0, 180000000, 1);
        send_point(0, -180000000, 0);              // same meridian via wrap
        send_point(0, 0, 0);
        send_point(0, 179999999, 0);               // near antipode
        send_point(-134217728, -268435456, 1);     // most negative fields, clamped
        send_point(134217727, 268435455, 0);       // most positive fields
        send_point(45000000, 90000000, 0);
        send_point(-45000000, -90000000, 0);       // antipodal
        send_point(1, 1, 0);
        send_point(0, 0, 0);
        send_point(12345678, 100000000, 0);
        send_point(12345678, 100000001, 0);        // one micro-degree

        // long hold-off while points keep coming: input must back up
        hold_cycles = 2000;
        repeat (6) random_point(0);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = phase == 0 ? 25 : phase == 1 ? 65 : 0;
            recv_idle = phase == 0 ? 65 : phase == 1 ? 25 : 0;
            for (int n = 0; n < 345; n++) random_point($urandom_range(19) == 0);
        end
        s_tvalid <= 0;

        while (pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        $display("%0d route points driven, %0d result beats checked, routes restarted at random",
                 beats_sent, results_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
